[hw/rtl/dvad_pkg.sv]
// Shared types, constants and calendar functions for the date age-difference block.
package dvad_pkg;

	localparam int unsigned DayW    = 7;
	localparam int unsigned MonthW  = 7;
	localparam int unsigned YearW   = 14;
	localparam int unsigned MonthsW = 4;
	localparam int unsigned DaysW   = 5;
	localparam int unsigned LenW    = 5;

	localparam logic [YearW-1:0] MaxYearReset = 14'd2024;

	localparam logic [MonthW-1:0] MonthJan      = 7'd1;
	localparam logic [MonthW-1:0] MonthFeb      = 7'd2;
	localparam logic [MonthW-1:0] MonthsPerYear = 7'd12;
	localparam logic [LenW-1:0]   LeapFebLen    = 5'd29;

	// Modular inverse of 25 mod 2^14 and the divisibility limit floor((2^14-1)/25)
	localparam logic [YearW-1:0] Inv25      = 14'd7209;
	localparam logic [YearW-1:0] Div25Limit = 14'd655;

	localparam logic [LenW-1:0] MonthLen [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOW_BAD     = 2'd1,
		ST_BIRTH_AFTER = 2'd2,
		ST_BIRTH_BAD   = 2'd3
	} status_t;

	typedef struct packed {
		logic [DayW-1:0]   now_day;
		logic [MonthW-1:0] now_month;
		logic [YearW-1:0]  now_year;
		logic [DayW-1:0]   birth_day;
		logic [MonthW-1:0] birth_month;
		logic [YearW-1:0]  birth_year;
	} date_pair_t;

	typedef struct packed {
		status_t            status;
		logic [YearW-1:0]   age_years;
		logic [MonthsW-1:0] age_months;
		logic [DaysW-1:0]   age_days;
		logic               born_today;
		logic               birthday_today;
	} age_res_t;

	// Gregorian leap rule; divisibility by 25 through the odd-divisor inverse test
	function automatic logic is_leap(input logic [YearW-1:0] y);
		logic [YearW-1:0] lo;
		logic div4;
		logic div16;
		logic div25;
		lo    = y * Inv25;
		div4  = (y[1:0] == 2'b00);
		div16 = (y[3:0] == 4'b0000);
		div25 = (lo <= Div25Limit);
		return (div4 && !div25) || (div16 && div25);
	endfunction

	// Month length, zero for a month out of range
	function automatic logic [LenW-1:0] days_in(input logic [MonthW-1:0] m, input logic leap);
		logic [MonthW-1:0] idx;
		idx = m - MonthJan;
		if (m < MonthJan || m > MonthsPerYear) begin
			return '0;
		end
		if (m == MonthFeb && leap) begin
			return LeapFebLen;
		end
		return MonthLen[idx[3:0]];
	endfunction

endpackage

[hw/rtl/dvad_if.sv]
// Valid/ready channel interfaces for date pairs and age results.
interface dvad_in_if;
	import dvad_pkg::*;

	logic       valid;
	logic       ready;
	date_pair_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dvad_out_if;
	import dvad_pkg::*;

	logic     valid;
	logic     ready;
	age_res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/dvad_calc.sv]
// Date validation, status precedence and borrow arithmetic for one date pair.
module dvad_calc (
	input  dvad_pkg::date_pair_t       pair,
	input  logic [dvad_pkg::YearW-1:0] max_year,
	output dvad_pkg::age_res_t         res
);
	import dvad_pkg::*;

	logic            now_leap;
	logic            birth_leap;
	logic [LenW-1:0] now_len;
	logic [LenW-1:0] birth_len;
	logic            now_ok;
	logic            birth_ok;
	logic            after;
	status_t         status;

	logic signed [YearW:0]  yr;
	logic signed [MonthW:0] mo;
	logic signed [DayW:0]   dy;

	// Check both dates against month range, month length and year limit, and compare their order
	always_comb begin
		now_leap   = is_leap(pair.now_year);
		birth_leap = is_leap(pair.birth_year);
		now_len    = days_in(pair.now_month, now_leap);
		birth_len  = days_in(pair.birth_month, birth_leap);
		now_ok     = (pair.now_month >= MonthJan) && (pair.now_month <= MonthsPerYear)
			&& (pair.now_day != '0) && (pair.now_day <= DayW'(now_len))
			&& (pair.now_year <= max_year);
		birth_ok   = (pair.birth_month >= MonthJan) && (pair.birth_month <= MonthsPerYear)
			&& (pair.birth_day != '0) && (pair.birth_day <= DayW'(birth_len))
			&& (pair.birth_year <= max_year);
		after      = (pair.birth_year > pair.now_year)
			|| (pair.birth_year == pair.now_year && pair.birth_month > pair.now_month)
			|| (pair.birth_year == pair.now_year && pair.birth_month == pair.now_month
				&& pair.birth_day > pair.now_day);
	end

	// Pick status by precedence: current date, ordering, birth date
	always_comb begin
		if (!now_ok) begin
			status = ST_NOW_BAD;
		end else if (after) begin
			status = ST_BIRTH_AFTER;
		end else if (!birth_ok) begin
			status = ST_BIRTH_BAD;
		end else begin
			status = ST_OK;
		end
	end

	// Subtract field by field, borrow a year into months and the current month's length into days
	always_comb begin
		yr = $signed({1'b0, pair.now_year}) - $signed({1'b0, pair.birth_year});
		mo = $signed({1'b0, pair.now_month}) - $signed({1'b0, pair.birth_month});
		dy = $signed({1'b0, pair.now_day}) - $signed({1'b0, pair.birth_day});
		if (mo < 0) begin
			yr = yr - 2'sd1;
			mo = mo + $signed({1'b0, MonthsPerYear});
		end
		if (mo == 0 && dy < 0) begin
			yr = yr - 2'sd1;
			mo = mo + $signed({1'b0, MonthsPerYear});
		end
		if (dy < 0) begin
			mo = mo - 2'sd1;
			dy = dy + $signed({3'b000, now_len});
		end
	end

	// Drive the result, clamping negatives and zeroing ages unless ok
	always_comb begin
		res.status         = status;
		res.age_years      = '0;
		res.age_months     = '0;
		res.age_days       = '0;
		res.born_today     = (pair.now_day == pair.birth_day)
			&& (pair.now_month == pair.birth_month) && (pair.now_year == pair.birth_year);
		res.birthday_today = (pair.now_day == pair.birth_day)
			&& (pair.now_month == pair.birth_month);
		if (status == ST_OK) begin
			res.age_years  = (yr < 0) ? '0 : yr[YearW-1:0];
			res.age_months = (mo < 0) ? '0 : mo[MonthsW-1:0];
			res.age_days   = (dy < 0) ? '0 : dy[DaysW-1:0];
		end
	end

endmodule

[hw/rtl/date_validate_age_difference_core.sv]
// Top level of the date age-difference block: input register, calculation, result register.
//
//   channel   direction  handshake            payload
//   date_in   in         valid/ready          now and birth day, month, year
//   age_out   out        valid/ready          status, years, months, days, flags
//   cfg       in         cfg_we (no ready)    max_year
//
// One date pair per cycle sustained while age_out is not stalled; a result item passes
// the input register, then the result register, before it turns valid.
// arst_n clears both stage valid bits and sets max_year to 2024.
// A stalled result holds in the result register; date_in stays ready while either
// stage has room or the result is being taken in the same cycle.
module date_validate_age_difference_core (
	input  logic                       clk,
	input  logic                       arst_n,
	dvad_in_if.sink                    date_in,
	dvad_out_if.source                 age_out,
	input  logic                       cfg_we,
	input  logic [dvad_pkg::YearW-1:0] cfg_wdata
);
	import dvad_pkg::*;

	logic [YearW-1:0] max_year_q;
	logic             v_s1;
	date_pair_t       pair_s1;
	logic             v_s2;
	age_res_t         res_s2;
	age_res_t         res_calc;
	logic             adv_s2;
	logic             adv_s1;

	// Hold the year limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_year_q <= MaxYearReset;
		end else if (cfg_we) begin
			max_year_q <= cfg_wdata;
		end
	end

	// Advance when the next stage has room or is draining
	assign adv_s2        = !v_s2 || age_out.ready;
	assign adv_s1        = !v_s1 || adv_s2;
	assign date_in.ready = adv_s1;

	// Capture the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= date_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && date_in.valid) begin
			pair_s1 <= date_in.data;
		end
	end

	dvad_calc u_calc (
		.pair     (pair_s1),
		.max_year (max_year_q),
		.res      (res_calc)
	);

	// Register the result item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2 <= res_calc;
		end
	end

	assign age_out.valid = v_s2;
	assign age_out.data  = res_s2;

endmodule

[hw/rtl/dvad_checker.sv]
// Port-level checks on the age-difference result channel, bound to the top level.
module dvad_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input dvad_pkg::age_res_t out_data
);
	import dvad_pkg::*;

	// Hold a stalled result item
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// Ages are zero unless the status is ok
	a_zero_ages: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
			out_data.age_years == '0 && out_data.age_months == '0 && out_data.age_days == '0)
		else $error("nonzero age with error status");

	// Remaining months stay below a year
	a_months_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.age_months <= MonthsW'(11))
		else $error("age_months out of range");

	// Identical dates imply a matching birthday
	a_born_implies_bday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.born_today |-> out_data.birthday_today)
		else $error("born_today without birthday_today");

	// Born today with a valid date gives a zero age
	a_born_zero_age: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.born_today && out_data.status == ST_OK |->
			out_data.age_years == '0 && out_data.age_months == '0 && out_data.age_days == '0)
		else $error("nonzero age for identical dates");

endmodule

bind date_validate_age_difference_core dvad_checker u_dvad_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (age_out.valid),
	.out_ready (age_out.ready),
	.out_data  (age_out.data)
);

[tb/sv/tb_date_validate_age_difference_core.sv]
// Testbench for the date age-difference block: random and directed date pairs checked against a predictor.
module tb_date_validate_age_difference_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dvad_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 8;
	localparam int SEG_ITEMS     = 150;
	localparam int NUM_SEGS      = 8;
	localparam int unsigned YEAR_TOP = (1 << YearW) - 1;
	localparam int MONTH_TAB [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned CAP_LIST [NUM_SEGS] = '{9999, 0, 2024, 0, 1, 400, 9998, 0};

	typedef struct packed {
		logic [DayW-1:0]   d;
		logic [MonthW-1:0] m;
		logic [YearW-1:0]  y;
	} cal_date_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [YearW-1:0] cfg_wdata;

	dvad_in_if  date_in_ch ();
	dvad_out_if age_out_ch ();

	date_validate_age_difference_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.date_in   (date_in_ch),
		.age_out   (age_out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	date_pair_t pending_pairs [$];
	age_res_t   expected_ages [$];
	logic [YearW-1:0] max_year_model;

	int  sender_idle_pct;
	int  recv_stall_pct;
	bit  send_hold;
	int  error_count;
	int  accepted_count;
	int  result_count;
	int  cfg_writes;
	int  cycle_count;
	bit  item_sent;
	bit  fields_match;
	age_res_t expected_age;

	int unsigned seg;
	int unsigned cap;
	date_pair_t  directed [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit leap_year(int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic int month_days(int unsigned m, int unsigned y);
		if (m < 1 || m > 12) begin
			return 0;
		end
		if (m == 2 && leap_year(y)) begin
			return 29;
		end
		return MONTH_TAB[m - 1];
	endfunction

	function automatic bit date_valid(cal_date_t dt, int unsigned lim);
		if (dt.m < 1 || dt.m > 12) begin
			return 1'b0;
		end
		if (dt.d < 1 || dt.d > month_days(dt.m, dt.y)) begin
			return 1'b0;
		end
		return dt.y <= lim;
	endfunction

	// Compare by year, then month, then day
	function automatic bit birth_after(cal_date_t nw, cal_date_t bt);
		return (bt.y > nw.y) || (bt.y == nw.y && bt.m > nw.m) ||
			(bt.y == nw.y && bt.m == nw.m && bt.d > nw.d);
	endfunction

	// Expected age result for one date pair under the given year limit
	function automatic age_res_t predict_age(date_pair_t p, int unsigned lim);
		age_res_t  r;
		cal_date_t nw;
		cal_date_t bt;
		int yrs;
		int mons;
		int dys;
		nw = '{p.now_day, p.now_month, p.now_year};
		bt = '{p.birth_day, p.birth_month, p.birth_year};
		r = '0;
		if (!date_valid(nw, lim)) begin
			r.status = ST_NOW_BAD;
		end else if (birth_after(nw, bt)) begin
			r.status = ST_BIRTH_AFTER;
		end else if (!date_valid(bt, lim)) begin
			r.status = ST_BIRTH_BAD;
		end else begin
			r.status = ST_OK;
		end
		if (r.status == ST_OK) begin
			yrs  = int'(nw.y) - int'(bt.y);
			mons = int'(nw.m) - int'(bt.m);
			dys  = int'(nw.d) - int'(bt.d);
			// Borrow a year into months, also when the months match but days fall short
			if (mons < 0) begin
				yrs--;
				mons += 12;
			end
			if (mons == 0 && dys < 0) begin
				yrs--;
				mons += 12;
			end
			// Borrow the current month's length into days
			if (dys < 0) begin
				mons--;
				dys += month_days(nw.m, nw.y);
			end
			if (dys < 0) dys = 0;
			if (yrs < 0) yrs = 0;
			if (mons < 0) mons = 0;
			r.age_years  = yrs[YearW-1:0];
			r.age_months = mons[MonthsW-1:0];
			r.age_days   = dys[DaysW-1:0];
		end
		r.born_today     = (nw == bt);
		r.birthday_today = (nw.d == bt.d && nw.m == bt.m);
		return r;
	endfunction

	function automatic date_pair_t mk(int nd, int nm, int ny, int bd, int bm, int by);
		date_pair_t p;
		p.now_day     = nd[DayW-1:0];
		p.now_month   = nm[MonthW-1:0];
		p.now_year    = ny[YearW-1:0];
		p.birth_day   = bd[DayW-1:0];
		p.birth_month = bm[MonthW-1:0];
		p.birth_year  = by[YearW-1:0];
		return p;
	endfunction

	// Valid date up to lim, with extra weight on leap February and month ends
	function automatic cal_date_t random_valid_date(int unsigned lim);
		cal_date_t dt;
		int len;
		dt.m = MonthW'($urandom_range(1, 12));
		dt.y = YearW'($urandom_range(0, lim));
		if ($urandom_range(0, 4) == 0) begin
			dt.m = MonthFeb;
			dt.y = YearW'((lim / 4) * 4 - 4 * $urandom_range(0, lim / 4));
		end
		len = month_days(dt.m, dt.y);
		dt.d = DayW'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
		return dt;
	endfunction

	// Break one field of a valid date
	function automatic cal_date_t break_date(cal_date_t dt, int unsigned lim);
		cal_date_t r;
		r = dt;
		case ($urandom_range(0, 3))
			0: r.m = MonthW'($urandom_range(0, 1) ? 0 : $urandom_range(13, 127));
			1: r.d = '0;
			2: r.d = DayW'($urandom_range(month_days(dt.m, dt.y) + 1, 127));
			default: r.y = YearW'($urandom_range(lim + 1, YEAR_TOP));
		endcase
		return r;
	endfunction

	function automatic date_pair_t random_pair(int unsigned lim);
		cal_date_t nw;
		cal_date_t bt;
		cal_date_t tmp;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		nw = random_valid_date(lim);
		bt = random_valid_date(lim);
		if (kind >= 40 && kind < 65) begin
			bt.y = nw.y;
			if (kind >= 55) bt.m = nw.m;
			if (bt.d > month_days(bt.m, bt.y)) bt.d = DayW'(month_days(bt.m, bt.y));
		end else if (kind >= 65 && kind < 70) begin
			bt.d = nw.d;
			bt.m = nw.m;
			bt.y = YearW'($urandom_range(0, nw.y));
		end
		// Order the two dates: birth first, except for the birth-after kind
		if (kind < 65 || (kind >= 78 && kind < 94)) begin
			if (birth_after(nw, bt)) begin
				tmp = nw;
				nw = bt;
				bt = tmp;
			end
		end else if (kind >= 70 && kind < 78) begin
			if (!birth_after(nw, bt)) begin
				tmp = nw;
				nw = bt;
				bt = tmp;
			end
		end
		if (kind >= 78 && kind < 86) nw = break_date(nw, lim);
		if (kind >= 86 && kind < 94) bt = break_date(bt, lim);
		if (kind >= 94) begin
			nw = $bits(cal_date_t)'($urandom());
			bt = $bits(cal_date_t)'($urandom());
		end
		return mk(nw.d, nw.m, nw.y, bt.d, bt.m, bt.y);
	endfunction

	function automatic bit field_ok(string name, logic [YearW-1:0] exp, logic [YearW-1:0] act);
		if (act !== exp) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Wait until no item is queued or in flight, then let the pipeline settle
	task automatic wait_drained();
		while (pending_pairs.size() != 0 || expected_ages.size() != 0 || date_in_ch.valid) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_max_year(int unsigned value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value[YearW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		max_year_model = value[YearW-1:0];
		cfg_writes++;
		@(negedge clk);
	endtask

	// Drive date pairs from the pending queue; hold an item until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_in_ch.valid <= 1'b0;
			date_in_ch.data  <= '0;
		end else begin
			item_sent = date_in_ch.valid && date_in_ch.ready;
			if (item_sent) begin
				expected_ages.push_back(predict_age(pending_pairs.pop_front(), max_year_model));
				accepted_count++;
			end
			if (date_in_ch.valid && !item_sent) begin
				// hold the current item
			end else if (pending_pairs.size() != 0 && !send_hold &&
					$urandom_range(0, 99) >= sender_idle_pct) begin
				date_in_ch.valid <= 1'b1;
				date_in_ch.data  <= pending_pairs[0];
			end else begin
				date_in_ch.valid <= 1'b0;
			end
		end
	end

	// Take results, check each against the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_out_ch.ready <= 1'b0;
		end else begin
			if (age_out_ch.valid && age_out_ch.ready) begin
				result_count++;
				if (expected_ages.size() == 0) begin
					$display("%0t: result with no pending item, got status %0d years %0d",
						$time, age_out_ch.data.status, age_out_ch.data.age_years);
					error_count++;
				end else begin
					expected_age = expected_ages.pop_front();
					fields_match = field_ok("status", YearW'(expected_age.status),
							YearW'(age_out_ch.data.status)) &
						field_ok("age_years", expected_age.age_years, age_out_ch.data.age_years) &
						field_ok("age_months", YearW'(expected_age.age_months),
							YearW'(age_out_ch.data.age_months)) &
						field_ok("age_days", YearW'(expected_age.age_days),
							YearW'(age_out_ch.data.age_days)) &
						field_ok("born_today", YearW'(expected_age.born_today),
							YearW'(age_out_ch.data.born_today)) &
						field_ok("birthday_today", YearW'(expected_age.birthday_today),
							YearW'(age_out_ch.data.birthday_today));
					if (!fields_match) error_count++;
				end
			end
			age_out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items queued and %0d results outstanding",
				$time, pending_pairs.size(), expected_ages.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		date_in_ch.valid = 1'b0;
		date_in_ch.data  = '0;
		age_out_ch.ready = 1'b0;
		max_year_model   = MaxYearReset;
		sender_idle_pct  = 0;
		recv_stall_pct   = 0;
		send_hold        = 1'b0;
		error_count      = 0;
		accepted_count   = 0;
		result_count     = 0;
		cfg_writes       = 0;
		cycle_count      = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pairs under the reset year limit
		directed.push_back(mk(15, 6, 2000, 15, 6, 2000));
		directed.push_back(mk(10, 3, 2020, 10, 3, 1990));
		directed.push_back(mk(1, 3, 2023, 31, 1, 2023));
		directed.push_back(mk(1, 2, 2023, 31, 1, 2023));
		directed.push_back(mk(5, 6, 2020, 10, 6, 2010));
		directed.push_back(mk(29, 2, 2000, 1, 1, 1999));
		directed.push_back(mk(29, 2, 1900, 1, 1, 1800));
		directed.push_back(mk(29, 2, 2024, 29, 2, 2020));
		directed.push_back(mk(1, 3, 2024, 29, 2, 1900));
		directed.push_back(mk(0, 5, 2010, 1, 1, 2000));
		directed.push_back(mk(31, 4, 2010, 1, 1, 2000));
		directed.push_back(mk(1, 0, 2010, 1, 1, 2000));
		directed.push_back(mk(1, 13, 2010, 1, 1, 2000));
		directed.push_back(mk(1, 1, 2025, 1, 1, 2000));
		directed.push_back(mk(127, 127, 16383, 0, 0, 0));
		directed.push_back(mk(31, 12, 2024, 1, 1, 0));
		directed.push_back(mk(1, 1, 0, 1, 1, 0));
		directed.push_back(mk(10, 5, 2010, 10, 5, 2011));
		directed.push_back(mk(10, 5, 2010, 10, 6, 2010));
		directed.push_back(mk(10, 5, 2010, 11, 5, 2010));
		directed.push_back(mk(10, 5, 2010, 0, 0, 2009));
		directed.push_back(mk(10, 5, 2010, 32, 1, 2009));
		directed.push_back(mk(1, 1, 2000, 127, 127, 16383));
		directed.push_back(mk(0, 0, 0, 127, 127, 16383));
		foreach (directed[i]) pending_pairs.push_back(directed[i]);
		wait_drained();

		// Random segments: one year limit and one flow-control mode each
		for (seg = 0; seg < NUM_SEGS; seg++) begin
			cap = (seg == 3 || seg == 7) ? $urandom_range(0, 9999) : CAP_LIST[seg];
			program_max_year(cap);
			case (seg % 4)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			repeat (SEG_ITEMS) pending_pairs.push_back(random_pair(cap));
			// Halfway through, hold the sender until every result is back
			while (pending_pairs.size() > SEG_ITEMS / 2) @(negedge clk);
			send_hold = 1'b1;
			while (expected_ages.size() != 0 || date_in_ch.valid) @(negedge clk);
			repeat ($urandom_range(1, 6)) @(negedge clk);
			send_hold = 1'b0;
			wait_drained();
		end

		if (expected_ages.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_ages.size());
			error_count++;
		end
		$display("Run covered %0d date pairs and %0d results over %0d year-limit writes,",
			accepted_count, result_count, cfg_writes);
		$display("with free-flowing, sender-idle, receiver-stall and mixed handshake phases.");
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
